// ===== sv/asws_pkg.sv =====
// Shared types and constants for the sliding-window ARQ sender.
package asws_pkg;

    localparam int SEQ_W      = 32;
    localparam int TICK_W     = 16;
    localparam int WLIM_W     = 6;
    localparam int RESULT_MAX = 32;
    localparam int CNT_W      = 6;
    localparam int CFG_DATA_W = 32;
    localparam int CFG_IDX_W  = 2;

    // Event code of an input word
    typedef enum logic [1:0] {
        FUNC_NEW_SEG   = 2'd0,
        FUNC_ACK       = 2'd1,
        FUNC_TICK      = 2'd2,
        FUNC_EXHAUSTED = 2'd3
    } t_func;

    // Result code of an output word
    typedef enum logic [2:0] {
        KIND_SEND        = 3'd0,
        KIND_RESEND      = 3'd1,
        KIND_ACK_TAKEN   = 3'd2,
        KIND_ACK_IGNORED = 3'd3,
        KIND_WIN_FULL    = 3'd4,
        KIND_NO_ACTION   = 3'd5,
        KIND_FINISHED    = 3'd6,
        KIND_WAITING     = 3'd7
    } t_kind;

    // Classified command from the front end
    typedef enum logic [2:0] {
        OP_SEND    = 3'd0,
        OP_ACK_BAD = 3'd1,
        OP_ACK     = 3'd2,
        OP_TICK    = 3'd3,
        OP_DRAIN   = 3'd4
    } t_op;

    // Configuration register index
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ARQ_MODE     = 2'd0,
        CFG_WINDOW_LIMIT = 2'd1,
        CFG_START_SEQ    = 2'd2,
        CFG_TIMEOUT      = 2'd3
    } t_cfg_idx;

    // Engine sequencer states
    typedef enum logic [1:0] {
        ST_IDLE   = 2'd0,
        ST_EXEC   = 2'd1,
        ST_SLIDE  = 2'd2,
        ST_RESEND = 2'd3
    } t_state;

    typedef struct packed {
        t_func              func;
        logic [SEQ_W-1:0]   ack_seq;
        logic               ack_good;
    } t_in;

    typedef struct packed {
        t_kind              kind;
        logic [SEQ_W-1:0]   seq;
        logic [SEQ_W-1:0]   window_base;
        logic               last;
    } t_out;

    typedef struct packed {
        t_op                op;
        logic [SEQ_W-1:0]   ack_seq;
    } t_cmd;

    typedef struct packed {
        logic                  we;
        t_cfg_idx              idx;
        logic [CFG_DATA_W-1:0] data;
    } t_cfg_wr;

endpackage

// ===== sv/asws_front.sv =====
// Front end: input word queue and event classification.
module asws_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           push,
    output logic           full,
    input  asws_pkg::t_in  i_in,
    output logic           o_cmd_vld,
    output asws_pkg::t_cmd o_cmd,
    input  logic           i_cmd_take
);
    import asws_pkg::*;

    localparam int DEPTH = 2;
    localparam int PW    = 1;
    localparam int CW    = 2;

    t_in            r_mem [DEPTH];
    logic [PW-1:0]  r_wp;
    logic [PW-1:0]  r_rp;
    logic [CW-1:0]  r_cnt;
    logic           w_wr;
    logic           w_rd;
    t_in            w_head;

    assign full      = (r_cnt == CW'(DEPTH));
    assign o_cmd_vld = (r_cnt != '0);
    assign w_wr      = push && !full;
    assign w_rd      = i_cmd_take && o_cmd_vld;

    // queue pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_wr) begin
                r_wp <= r_wp + 1'b1;
            end
            if (w_rd) begin
                r_rp <= r_rp + 1'b1;
            end
            r_cnt <= r_cnt + CW'(w_wr) - CW'(w_rd);
        end
    end

    // queue storage
    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wp] <= i_in;
        end
    end

    // classify the oldest word
    always_comb begin
        w_head        = r_mem[r_rp];
        o_cmd.ack_seq = w_head.ack_seq;
        unique case (w_head.func)
            FUNC_NEW_SEG:   o_cmd.op = OP_SEND;
            FUNC_ACK:       o_cmd.op = w_head.ack_good ? OP_ACK : OP_ACK_BAD;
            FUNC_TICK:      o_cmd.op = OP_TICK;
            FUNC_EXHAUSTED: o_cmd.op = OP_DRAIN;
        endcase
    end

endmodule

// ===== sv/asws_back.sv =====
// Back end: window state, ack marks, timer and the event sequencer.
module asws_back #(
    parameter int WINDOW_MAX = 32
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  asws_pkg::t_cfg_wr i_cfg,
    input  logic              i_cmd_vld,
    input  asws_pkg::t_cmd    i_cmd,
    output logic              o_cmd_take,
    output logic              o_res_vld,
    output asws_pkg::t_out    o_res,
    input  logic              i_res_full
);
    import asws_pkg::*;

    localparam int SW = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
    localparam logic [SW:0]       W_SUM     = (SW+1)'(WINDOW_MAX);
    localparam logic [SW-1:0]     SLOT_LAST = SW'(WINDOW_MAX - 1);
    localparam logic [WLIM_W-1:0] WIN_CAP   =
        WLIM_W'((WINDOW_MAX < RESULT_MAX) ? WINDOW_MAX : RESULT_MAX);

    // ring slot helpers; slots count from the start of the transfer
    function automatic logic [SW-1:0] slot_inc(input logic [SW-1:0] s);
        return (s == SLOT_LAST) ? '0 : s + 1'b1;
    endfunction

    function automatic logic [SW-1:0] slot_add(input logic [SW-1:0] b,
                                               input logic [SW:0] o);
        logic [SW:0] s;
        s = {1'b0, b} + o;
        if (s >= W_SUM) begin
            s = s - W_SUM;
        end
        return s[SW-1:0];
    endfunction

    t_state                 r_state, n_state;
    t_cmd                   r_cmd, n_cmd;
    logic                   r_mode;
    logic [WLIM_W-1:0]      r_wlim;
    logic [TICK_W-1:0]      r_tmo;
    logic [SEQ_W-1:0]       r_base, n_base;
    logic [SEQ_W-1:0]       r_next, n_next;
    logic [SW-1:0]          r_base_slot, n_base_slot;
    logic [SW-1:0]          r_next_slot, n_next_slot;
    logic [WINDOW_MAX-1:0]  r_marks, n_marks;
    logic [TICK_W-1:0]      r_idle, n_idle;
    logic [CNT_W-1:0]       r_walk_cnt, n_walk_cnt;
    logic [CNT_W-1:0]       r_walk_n, n_walk_n;
    logic [SW-1:0]          r_walk_slot, n_walk_slot;
    logic                   r_pend_vld, n_pend_vld;
    logic [SEQ_W-1:0]       r_pend_seq, n_pend_seq;

    logic [SEQ_W-1:0]       w_outst;
    logic [SEQ_W-1:0]       w_off;
    logic [WLIM_W-1:0]      w_eff;
    logic                   w_can_send;
    logic                   w_gbn_ok;
    logic                   w_sr_ok;
    logic [SW-1:0]          w_ack_slot;
    logic [TICK_W-1:0]      w_tick_lim;
    logic [TICK_W-1:0]      w_idle_inc;
    logic                   w_timeout;
    logic                   w_sr_slide;
    logic                   w_slide_stop;
    logic                   w_walk_end;
    logic                   w_walk_hit;
    logic [SEQ_W-1:0]       w_cand_seq;
    logic                   w_go;

    // shared decisions
    always_comb begin
        w_outst      = r_next - r_base;
        w_off        = r_cmd.ack_seq - r_base;
        w_eff        = (r_wlim == '0) ? WLIM_W'(1) :
                       ((r_wlim > WIN_CAP) ? WIN_CAP : r_wlim);
        w_can_send   = w_outst < {{(SEQ_W-WLIM_W){1'b0}}, w_eff};
        w_gbn_ok     = w_off <= w_outst;
        w_sr_ok      = w_off < w_outst;
        w_ack_slot   = slot_add(r_base_slot, w_off[SW:0]);
        w_tick_lim   = (r_tmo == '0) ? TICK_W'(1) : r_tmo;
        w_idle_inc   = (r_idle == '1) ? r_idle : r_idle + 1'b1;
        w_timeout    = w_idle_inc >= w_tick_lim;
        w_sr_slide   = r_mode && w_sr_ok && (w_off == '0);
        w_slide_stop = (r_base == r_next) || !r_marks[r_base_slot];
        w_walk_end   = (r_walk_cnt == r_walk_n);
        w_walk_hit   = !r_mode || !r_marks[r_walk_slot];
        w_cand_seq   = r_base + SEQ_W'(r_walk_cnt);
        w_go         = !i_res_full;
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_cmd_vld) begin
                    n_state = ST_EXEC;
                end
            end
            ST_EXEC: begin
                priority if (r_cmd.op == OP_ACK && w_sr_slide) begin
                    n_state = ST_SLIDE;
                end else if (r_cmd.op == OP_TICK && w_timeout) begin
                    n_state = ST_RESEND;
                end else if (w_go) begin
                    n_state = ST_IDLE;
                end else begin
                    n_state = ST_EXEC;
                end
            end
            ST_SLIDE: begin
                if (w_slide_stop && w_go) begin
                    n_state = ST_IDLE;
                end
            end
            ST_RESEND: begin
                if (w_walk_end && w_go) begin
                    n_state = ST_IDLE;
                end
            end
        endcase
    end

    // outputs and datapath updates
    always_comb begin
        o_cmd_take        = 1'b0;
        o_res_vld         = 1'b0;
        o_res.kind        = KIND_NO_ACTION;
        o_res.seq         = '0;
        o_res.window_base = r_base;
        o_res.last        = 1'b1;
        n_cmd             = r_cmd;
        n_base            = r_base;
        n_next            = r_next;
        n_base_slot       = r_base_slot;
        n_next_slot       = r_next_slot;
        n_marks           = r_marks;
        n_idle            = r_idle;
        n_walk_cnt        = r_walk_cnt;
        n_walk_n          = r_walk_n;
        n_walk_slot       = r_walk_slot;
        n_pend_vld        = r_pend_vld;
        n_pend_seq        = r_pend_seq;

        unique case (r_state)
            ST_IDLE: begin
                o_cmd_take = i_cmd_vld;
                if (i_cmd_vld) begin
                    n_cmd = i_cmd;
                end
            end
            ST_EXEC: begin
                o_res_vld = 1'b1;
                unique case (r_cmd.op)
                    OP_SEND: begin
                        if (w_can_send) begin
                            o_res.kind = KIND_SEND;
                            o_res.seq  = r_next;
                            if (w_go) begin
                                n_marks[r_next_slot] = 1'b0;
                                n_next               = r_next + 1'b1;
                                n_next_slot          = slot_inc(r_next_slot);
                                if (!r_mode) begin
                                    n_idle = '0;
                                end
                            end
                        end else begin
                            o_res.kind = KIND_WIN_FULL;
                        end
                    end
                    OP_ACK_BAD: begin
                        o_res.kind = KIND_ACK_IGNORED;
                    end
                    OP_ACK: begin
                        if (!r_mode) begin
                            // cumulative ack: base jumps to the ack value
                            if (w_gbn_ok) begin
                                o_res.kind        = KIND_ACK_TAKEN;
                                o_res.window_base = r_cmd.ack_seq;
                                if (w_go) begin
                                    n_base      = r_cmd.ack_seq;
                                    n_base_slot = w_ack_slot;
                                    if (r_cmd.ack_seq != r_next) begin
                                        n_idle = '0;
                                    end
                                end
                            end else begin
                                o_res.kind = KIND_ACK_IGNORED;
                            end
                        end else if (w_sr_ok) begin
                            // selective ack: mark it, slide when it is the base
                            o_res.kind = KIND_ACK_TAKEN;
                            if (w_sr_slide) begin
                                o_res_vld           = 1'b0;
                                n_marks[w_ack_slot] = 1'b1;
                            end else if (w_go) begin
                                n_marks[w_ack_slot] = 1'b1;
                            end
                        end else begin
                            o_res.kind = KIND_ACK_IGNORED;
                        end
                    end
                    OP_TICK: begin
                        if (w_timeout) begin
                            o_res_vld   = 1'b0;
                            n_idle      = '0;
                            n_walk_cnt  = '0;
                            n_walk_n    = w_outst[CNT_W-1:0];
                            n_walk_slot = r_base_slot;
                            n_pend_vld  = 1'b0;
                        end else begin
                            o_res.kind = (w_outst != '0) ? KIND_WAITING : KIND_NO_ACTION;
                            if (w_go) begin
                                n_idle = w_idle_inc;
                            end
                        end
                    end
                    OP_DRAIN: begin
                        o_res.kind = (r_base == r_next) ? KIND_FINISHED : KIND_WAITING;
                    end
                    default: begin
                        o_res.kind = KIND_NO_ACTION;
                    end
                endcase
            end
            ST_SLIDE: begin
                // one marked entry leaves the window per cycle
                if (w_slide_stop) begin
                    o_res_vld  = 1'b1;
                    o_res.kind = KIND_ACK_TAKEN;
                end else begin
                    n_marks[r_base_slot] = 1'b0;
                    n_base               = r_base + 1'b1;
                    n_base_slot          = slot_inc(r_base_slot);
                end
            end
            ST_RESEND: begin
                // walk the window; hold one hit back so the final one gets last
                if (w_walk_end) begin
                    o_res_vld  = 1'b1;
                    o_res.kind = r_pend_vld ? KIND_RESEND : KIND_NO_ACTION;
                    o_res.seq  = r_pend_vld ? r_pend_seq : '0;
                end else if (w_walk_hit && r_pend_vld) begin
                    o_res_vld  = 1'b1;
                    o_res.kind = KIND_RESEND;
                    o_res.seq  = r_pend_seq;
                    o_res.last = 1'b0;
                    if (w_go) begin
                        n_pend_seq  = w_cand_seq;
                        n_walk_cnt  = r_walk_cnt + 1'b1;
                        n_walk_slot = slot_inc(r_walk_slot);
                    end
                end else begin
                    if (w_walk_hit) begin
                        n_pend_vld = 1'b1;
                        n_pend_seq = w_cand_seq;
                    end
                    n_walk_cnt  = r_walk_cnt + 1'b1;
                    n_walk_slot = slot_inc(r_walk_slot);
                end
            end
        endcase

        // a start_seq write opens a new transfer
        if (i_cfg.we && (i_cfg.idx == CFG_START_SEQ)) begin
            n_base      = i_cfg.data[SEQ_W-1:0];
            n_next      = i_cfg.data[SEQ_W-1:0];
            n_base_slot = '0;
            n_next_slot = '0;
            n_marks     = '0;
            n_idle      = '0;
        end
    end

    // control state and configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_mode      <= 1'b0;
            r_wlim      <= WLIM_W'(4);
            r_tmo       <= TICK_W'(100);
            r_base      <= '0;
            r_next      <= '0;
            r_base_slot <= '0;
            r_next_slot <= '0;
            r_marks     <= '0;
            r_idle      <= '0;
            r_walk_cnt  <= '0;
            r_walk_n    <= '0;
            r_walk_slot <= '0;
            r_pend_vld  <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_base      <= n_base;
            r_next      <= n_next;
            r_base_slot <= n_base_slot;
            r_next_slot <= n_next_slot;
            r_marks     <= n_marks;
            r_idle      <= n_idle;
            r_walk_cnt  <= n_walk_cnt;
            r_walk_n    <= n_walk_n;
            r_walk_slot <= n_walk_slot;
            r_pend_vld  <= n_pend_vld;
            if (i_cfg.we) begin
                unique case (i_cfg.idx)
                    CFG_ARQ_MODE:     r_mode <= i_cfg.data[0];
                    CFG_WINDOW_LIMIT: r_wlim <= i_cfg.data[WLIM_W-1:0];
                    CFG_START_SEQ:    ;  // transfer restart goes through the n_ values
                    CFG_TIMEOUT:      r_tmo  <= i_cfg.data[TICK_W-1:0];
                endcase
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_cmd      <= n_cmd;
        r_pend_seq <= n_pend_seq;
    end

endmodule

// ===== sv/asws_outq.sv =====
// Result queue between the engine and the result port.
module asws_outq (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    output logic           o_full,
    input  asws_pkg::t_out i_word,
    output logic           empty,
    input  logic           pop,
    output asws_pkg::t_out o_word
);
    import asws_pkg::*;

    localparam int DEPTH = 4;
    localparam int PW    = 2;
    localparam int CW    = 3;

    t_out           r_mem [DEPTH];
    logic [PW-1:0]  r_wp;
    logic [PW-1:0]  r_rp;
    logic [CW-1:0]  r_cnt;
    logic           w_wr;
    logic           w_rd;

    assign o_full = (r_cnt == CW'(DEPTH));
    assign empty  = (r_cnt == '0);
    assign w_wr   = i_push && !o_full;
    assign w_rd   = pop && !empty;
    assign o_word = r_mem[r_rp];

    // queue pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_wr) begin
                r_wp <= r_wp + 1'b1;
            end
            if (w_rd) begin
                r_rp <= r_rp + 1'b1;
            end
            r_cnt <= r_cnt + CW'(w_wr) - CW'(w_rd);
        end
    end

    // queue storage
    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wp] <= i_word;
        end
    end

endmodule

// ===== sv/arq_sliding_window_sender_top.sv =====
// Top level of the sliding-window ARQ sender.
// Sender side of a sliding-window ARQ in Go-Back-N or Selective Repeat mode.
// Events (new segment, ack, tick, data exhausted) are pushed into a two-word
// input queue; a sequencer executes them one at a time and pushes result
// words into a four-word result queue, so both sides may stall freely.
// A plain event is taken in the idle state and its result word is issued in
// the exec state, then reaches the result ports through the result queue.
// A Selective Repeat ack of the window base adds the slide state, where one
// marked entry leaves the window per cycle; a timeout adds the resend state,
// which walks the outstanding sequences reading one ack mark per cycle when
// not stalled by the result queue. A full result queue stalls the
// sequencer. The window ring holds WINDOW_MAX marks; writing start_seq starts
// a new transfer. Configure only while no event is in flight.
module arq_sliding_window_sender_top #(
    parameter int WINDOW_MAX = 32
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                push,
    output logic                                full,
    input  asws_pkg::t_in                       i_in,
    output logic                                empty,
    input  logic                                pop,
    output asws_pkg::t_out                      o_out,
    input  logic                                i_cfg_we,
    input  logic [asws_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [asws_pkg::CFG_DATA_W-1:0]     i_cfg_data
);
    import asws_pkg::*;

    t_cfg_wr w_cfg;
    logic    w_cmd_vld;
    t_cmd    w_cmd;
    logic    w_cmd_take;
    logic    w_res_vld;
    t_out    w_res;
    logic    w_res_full;

    // configuration write
    always_comb begin
        w_cfg.we   = i_cfg_we;
        w_cfg.idx  = t_cfg_idx'(i_cfg_idx);
        w_cfg.data = i_cfg_data;
    end

    asws_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .push       (push),
        .full       (full),
        .i_in       (i_in),
        .o_cmd_vld  (w_cmd_vld),
        .o_cmd      (w_cmd),
        .i_cmd_take (w_cmd_take)
    );

    asws_back #(
        .WINDOW_MAX (WINDOW_MAX)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (w_cfg),
        .i_cmd_vld  (w_cmd_vld),
        .i_cmd      (w_cmd),
        .o_cmd_take (w_cmd_take),
        .o_res_vld  (w_res_vld),
        .o_res      (w_res),
        .i_res_full (w_res_full)
    );

    asws_outq u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_res_vld),
        .o_full  (w_res_full),
        .i_word  (w_res),
        .empty   (empty),
        .pop     (pop),
        .o_word  (o_out)
    );

endmodule

// ===== tb/arq_sliding_window_sender_checker.sv =====
`timescale 1ns / 1ps
// Scoreboard for the ARQ sender: predicts every result word and compares it.
module arq_sliding_window_sender_checker #(
    parameter int WINDOW_MAX = 32
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_push,
    input  logic                               i_full,
    input  asws_pkg::t_in                      i_in,
    input  logic                               i_empty,
    input  logic                               i_pop,
    input  asws_pkg::t_out                     i_out,
    input  logic                               i_cfg_we,
    input  logic [asws_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [asws_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    output int                                 o_fail_cnt,
    output int                                 o_pending,
    output logic [asws_pkg::SEQ_W-1:0]         o_base,
    output logic [asws_pkg::SEQ_W-1:0]         o_next
);
    import asws_pkg::*;

    localparam int WIN_CAP = (WINDOW_MAX < RESULT_MAX) ? WINDOW_MAX : RESULT_MAX;

    // Predicted configuration and transfer state
    logic              sr_mode;
    logic [WLIM_W-1:0] win_lim;
    logic [SEQ_W-1:0]  start_seq;
    logic [TICK_W-1:0] tmo_ticks;
    logic [SEQ_W-1:0]  base_seq;
    logic [SEQ_W-1:0]  next_seq;
    logic              acked[WINDOW_MAX];
    logic [TICK_W-1:0] idle_ticks;

    // Result words still owed by the block, oldest first
    t_out              due_words[$];

    function automatic int unsigned slot_of(input logic [SEQ_W-1:0] s);
        return s % WINDOW_MAX;
    endfunction

    // Window limit saturated to 1 .. WIN_CAP
    function automatic int unsigned win_size();
        int unsigned w;
        w = win_lim;
        if (w < 1) w = 1;
        if (w > WIN_CAP) w = WIN_CAP;
        return w;
    endfunction

    function automatic t_out word_of(input t_kind k, input logic [SEQ_W-1:0] s);
        t_out w;
        w.kind        = k;
        w.seq         = s;
        w.window_base = '0;
        w.last        = 1'b0;
        return w;
    endfunction

    task automatic restart_transfer();
        base_seq   = start_seq;
        next_seq   = start_seq;
        idle_ticks = '0;
        foreach (acked[k]) acked[k] = 1'b0;
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] d);
        case (t_cfg_idx'(idx))
            CFG_ARQ_MODE:     sr_mode = d[0];
            CFG_WINDOW_LIMIT: win_lim = d[WLIM_W-1:0];
            CFG_START_SEQ: begin
                start_seq = d[SEQ_W-1:0];
                restart_transfer();
            end
            CFG_TIMEOUT:      tmo_ticks = d[TICK_W-1:0];
            default: ;
        endcase
    endtask

    // Work out the result words of one accepted event and queue them
    task automatic predict_event(input t_in w);
        logic [SEQ_W-1:0] outst;
        logic [SEQ_W-1:0] off;
        logic [SEQ_W-1:0] s;
        int unsigned      lim;
        int unsigned      n;
        t_out             words[$];
        begin
            outst = next_seq - base_seq;
            off   = w.ack_seq - base_seq;
            case (w.func)
                FUNC_NEW_SEG: begin
                    if (outst < win_size()) begin
                        words.push_back(word_of(KIND_SEND, next_seq));
                        acked[slot_of(next_seq)] = 1'b0;
                        next_seq++;
                        if (!sr_mode) idle_ticks = '0;
                    end else begin
                        words.push_back(word_of(KIND_WIN_FULL, '0));
                    end
                end
                FUNC_ACK: begin
                    if (!w.ack_good) begin
                        words.push_back(word_of(KIND_ACK_IGNORED, '0));
                    end else if (!sr_mode) begin
                        // cumulative ack, anywhere in [base, next]
                        if (off <= outst) begin
                            base_seq = w.ack_seq;
                            if (base_seq != next_seq) idle_ticks = '0;
                            words.push_back(word_of(KIND_ACK_TAKEN, '0));
                        end else begin
                            words.push_back(word_of(KIND_ACK_IGNORED, '0));
                        end
                    end else begin
                        // per-sequence mark, only for sequences already sent
                        if (off < outst) begin
                            acked[slot_of(w.ack_seq)] = 1'b1;
                            if (w.ack_seq == base_seq) begin
                                for (int i = 0; i < WINDOW_MAX; i++) begin
                                    if (base_seq == next_seq || !acked[slot_of(base_seq)])
                                        break;
                                    acked[slot_of(base_seq)] = 1'b0;
                                    base_seq++;
                                end
                            end
                            words.push_back(word_of(KIND_ACK_TAKEN, '0));
                        end else begin
                            words.push_back(word_of(KIND_ACK_IGNORED, '0));
                        end
                    end
                end
                FUNC_TICK: begin
                    lim = (tmo_ticks == 0) ? 1 : tmo_ticks;
                    if (idle_ticks != '1) idle_ticks++;
                    if (idle_ticks >= lim) begin
                        // timeout: resend outstanding sequences in order, skipping marked ones in SR mode
                        idle_ticks = '0;
                        n = (outst > RESULT_MAX) ? RESULT_MAX : outst;
                        for (int j = 0; j < n; j++) begin
                            s = base_seq + j;
                            if (!sr_mode || !acked[slot_of(s)])
                                words.push_back(word_of(KIND_RESEND, s));
                        end
                        if (words.size() == 0)
                            words.push_back(word_of(KIND_NO_ACTION, '0));
                    end else begin
                        words.push_back(word_of((outst != 0) ? KIND_WAITING : KIND_NO_ACTION,
                                                '0));
                    end
                end
                default: begin
                    words.push_back(word_of((base_seq == next_seq) ? KIND_FINISHED
                                                                   : KIND_WAITING, '0));
                end
            endcase
            foreach (words[i]) begin
                words[i].window_base = base_seq;
                words[i].last        = (i == words.size() - 1);
                due_words.push_back(words[i]);
            end
        end
    endtask

    task automatic check_word(input t_out got);
        t_out want;
        begin
            if (due_words.size() == 0) begin
                $error("result word with nothing expected: kind %0d seq %h base %h",
                       got.kind, got.seq, got.window_base);
                o_fail_cnt++;
            end else begin
                want = due_words.pop_front();
                if (got.kind !== want.kind) begin
                    $error("kind: expected %0d, actual %0d", want.kind, got.kind);
                    o_fail_cnt++;
                end
                if (got.seq !== want.seq) begin
                    $error("seq: expected %h, actual %h", want.seq, got.seq);
                    o_fail_cnt++;
                end
                if (got.window_base !== want.window_base) begin
                    $error("window_base: expected %h, actual %h",
                           want.window_base, got.window_base);
                    o_fail_cnt++;
                end
                if (got.last !== want.last) begin
                    $error("last: expected %0d, actual %0d", want.last, got.last);
                    o_fail_cnt++;
                end
            end
        end
    endtask

    // Watch both channels and the register port on every rising edge
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            sr_mode    = 1'b0;
            win_lim    = 4;
            start_seq  = '0;
            tmo_ticks  = 100;
            restart_transfer();
            due_words.delete();
            o_fail_cnt = 0;
        end else begin
            if (i_cfg_we) write_reg(i_cfg_idx, i_cfg_data);
            if (i_pop && !i_empty) check_word(i_out);
            if (i_push && !i_full) predict_event(i_in);
        end
        o_pending = due_words.size();
        o_base    = base_seq;
        o_next    = next_seq;
    end

endmodule

// ===== tb/tb_arq_sliding_window_sender_top.sv =====
`timescale 1ns / 1ps
// Testbench top for the ARQ sender: stimulus, stalls and the verdict.
module tb_arq_sliding_window_sender_top;
    import asws_pkg::*;

    localparam int WINDOW_MAX = 32;
    localparam int ITEM_GOAL  = 270;

    logic                  i_clk      = 1'b0;
    logic                  i_rst_n    = 1'b0;
    logic                  push       = 1'b0;
    t_in                   i_in       = '0;
    logic                  pop        = 1'b0;
    logic                  i_cfg_we   = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx  = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;
    logic                  full;
    logic                  empty;
    t_out                  o_out;

    int                    fail_cnt;
    int                    pending;
    logic [SEQ_W-1:0]      model_base;
    logic [SEQ_W-1:0]      model_next;

    int                    burst_left = 0;
    int                    items_done = 0;
    int                    stall_left = 0;
    int                    rx_cyc     = 0;
    bit                    quiet      = 1'b0;
    int unsigned           win;

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    arq_sliding_window_sender_top #(
        .WINDOW_MAX (WINDOW_MAX)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .push       (push),
        .full       (full),
        .i_in       (i_in),
        .empty      (empty),
        .pop        (pop),
        .o_out      (o_out),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    arq_sliding_window_sender_checker #(
        .WINDOW_MAX (WINDOW_MAX)
    ) u_checker (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_full     (full),
        .i_in       (i_in),
        .i_empty    (empty),
        .i_pop      (pop),
        .i_out      (o_out),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_fail_cnt (fail_cnt),
        .o_pending  (pending),
        .o_base     (model_base),
        .o_next     (model_next)
    );

    // Result side: random stalls, short and long, with quiet stretches
    initial begin
        forever begin
            @(negedge i_clk);
            if (stall_left > 0) begin
                pop = 1'b0;
                stall_left--;
            end else begin
                pop = 1'b1;
                if (!quiet && $urandom_range(0, 4) == 0)
                    stall_left = ($urandom_range(0, 15) == 0) ? $urandom_range(12, 25)
                                                              : $urandom_range(1, 4);
            end
            rx_cyc++;
            if (rx_cyc % 200 == 0) quiet = ($urandom_range(0, 2) == 0);
        end
    end

    // Hard stop in case the block hangs
    initial begin
        #10_000_000;
        $display("tb_arq_sliding_window_sender_top NOT OK");
        $finish;
    end

    // Push one event word; entered and left at a falling edge
    task automatic send_word(input t_func f, input logic [SEQ_W-1:0] a, input logic g);
        int gap;
        begin
            if (burst_left == 0) begin
                burst_left = $urandom_range(1, 16);
                gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                if (gap > 0) begin
                    push = 1'b0;
                    repeat (gap) @(negedge i_clk);
                end
            end
            burst_left--;
            push = 1'b1;
            i_in = '{f, a, g};
            @(posedge i_clk);
            while (full) @(posedge i_clk);
            items_done++;
            @(negedge i_clk);
        end
    endtask

    // Hold off until every owed result word has been taken
    task automatic drain_results();
        begin
            push = 1'b0;
            while (pending != 0) @(negedge i_clk);
        end
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [CFG_DATA_W-1:0] d);
        begin
            i_cfg_we   = 1'b1;
            i_cfg_idx  = idx;
            i_cfg_data = d;
            @(negedge i_clk);
            i_cfg_we   = 1'b0;
        end
    endtask

    // New setting on an idle block; start_seq also restarts the transfer
    task automatic start_phase(input logic mode, input int unsigned wl,
                               input logic [SEQ_W-1:0] first, input int unsigned tmo);
        begin
            drain_results();
            write_reg(CFG_ARQ_MODE, CFG_DATA_W'(mode));
            write_reg(CFG_WINDOW_LIMIT, wl);
            write_reg(CFG_START_SEQ, first);
            write_reg(CFG_TIMEOUT, tmo);
        end
    endtask

    // One random event, mostly well-formed acks against the live window
    task automatic random_event();
        int unsigned      pick;
        logic [SEQ_W-1:0] outst;
        begin
            pick  = $urandom_range(0, 99);
            outst = model_next - model_base;
            if (pick < 35) begin
                send_word(FUNC_NEW_SEG, $urandom, 1'($urandom_range(0, 1)));
            end else if (pick < 70) begin
                if ($urandom_range(0, 9) < 7) begin
                    send_word(FUNC_ACK, ($urandom_range(0, 2) == 0)
                              ? model_base : model_base + $urandom_range(0, outst), 1'b1);
                end else begin
                    // noise: random value, random check flag
                    send_word(FUNC_ACK, $urandom, 1'($urandom_range(0, 1)));
                end
            end else if (pick < 90) begin
                send_word(FUNC_TICK, $urandom, 1'($urandom_range(0, 1)));
            end else begin
                send_word(FUNC_EXHAUSTED, $urandom, 1'($urandom_range(0, 1)));
            end
        end
    endtask

    initial begin
        repeat (4) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Go-Back-N across the 2^32 wrap, window 4, timeout after 2 ticks
        start_phase(1'b0, 4, 32'hFFFF_FFFE, 2);
        send_word(FUNC_EXHAUSTED, '0, 1'b0);          // nothing sent: finished
        send_word(FUNC_TICK, '0, 1'b0);               // idle, no timeout
        send_word(FUNC_TICK, '0, 1'b0);               // timeout with nothing out
        repeat (5) send_word(FUNC_NEW_SEG, '0, 1'b0); // fifth one hits a full window
        send_word(FUNC_ACK, 32'hFFFF_FFFF, 1'b0);     // bad checksum
        send_word(FUNC_ACK, 32'hFFFF_FFFD, 1'b1);     // below the base
        send_word(FUNC_EXHAUSTED, '1, 1'b1);          // still waiting
        send_word(FUNC_TICK, '1, 1'b1);
        send_word(FUNC_TICK, '1, 1'b1);               // go back: resend all four
        send_word(FUNC_ACK, 32'h0000_0000, 1'b1);     // cumulative ack mid-window
        send_word(FUNC_ACK, 32'h0000_0002, 1'b1);     // ack of next: all done
        send_word(FUNC_EXHAUSTED, '0, 1'b0);

        // Selective Repeat, window 3, timeout on every tick
        start_phase(1'b1, 3, 32'hFFFF_FFF0, 1);
        repeat (3) send_word(FUNC_NEW_SEG, '0, 1'b0);
        send_word(FUNC_ACK, 32'hFFFF_FFF1, 1'b1);     // mark out of order
        send_word(FUNC_ACK, 32'hFFFF_FFF3, 1'b1);     // not yet sent: ignored
        send_word(FUNC_TICK, '0, 1'b0);               // resend only unmarked
        send_word(FUNC_ACK, 32'hFFFF_FFF0, 1'b1);     // base slides over the mark
        send_word(FUNC_ACK, 32'hFFFF_FFF0, 1'b1);     // stale, below base
        send_word(FUNC_ACK, 32'hFFFF_FFF2, 1'b0);     // bad checksum
        send_word(FUNC_ACK, 32'hFFFF_FFF2, 1'b1);
        send_word(FUNC_TICK, '0, 1'b0);               // timeout, nothing left
        send_word(FUNC_EXHAUSTED, '0, 1'b0);

        // Random phases, each with a fresh setting and transfer
        while (items_done < ITEM_GOAL) begin
            case ($urandom_range(0, 3))
                0:       win = 1;
                1:       win = 32;
                default: win = $urandom_range(2, 31);
            endcase
            start_phase(1'($urandom_range(0, 1)), win,
                        ($urandom_range(0, 2) == 0) ? 32'hFFFF_FFFF - $urandom_range(0, 40)
                        : ($urandom_range(0, 3) == 0) ? 32'h0 : $urandom,
                        ($urandom_range(0, 3) == 0) ? 1
                        : ($urandom_range(0, 4) == 0) ? 65535 : $urandom_range(2, 8));
            // push up to one segment past the window first so timeouts have work
            repeat ($urandom_range(0, win + 1)) begin
                if (items_done < ITEM_GOAL)
                    send_word(FUNC_NEW_SEG, $urandom, 1'($urandom_range(0, 1)));
            end
            repeat ($urandom_range(15, 40)) begin
                if (items_done < ITEM_GOAL) begin
                    random_event();
                    if ($urandom_range(0, 29) == 0) drain_results();
                end
            end
        end

        drain_results();
        repeat (40) @(negedge i_clk);
        if (fail_cnt == 0 && pending == 0)
            $display("tb_arq_sliding_window_sender_top OK");
        else
            $display("tb_arq_sliding_window_sender_top NOT OK");
        $finish;
    end

endmodule
